>>> design/cau_pkg.sv
`default_nettype none

package cau_pkg;

  localparam logic [2:0] KIND_ADD   = 3'd0;
  localparam logic [2:0] KIND_SUB   = 3'd1;
  localparam logic [2:0] KIND_MUL   = 3'd2;
  localparam logic [2:0] KIND_DIV   = 3'd3;
  localparam logic [2:0] KIND_CONJ  = 3'd4;
  localparam logic [2:0] KIND_NORM  = 3'd5;
  localparam logic [2:0] KIND_EQUAL = 3'd6;

  // quotient bits produced per divide
  localparam int DIV_QBITS = 34;

  typedef struct packed {
    logic [2:0]         kind;
    logic signed [31:0] a_real;
    logic signed [31:0] a_imag;
    logic signed [31:0] b_real;
    logic signed [31:0] b_imag;
  } req_t;

  typedef struct packed {
    logic signed [31:0] res_real;
    logic signed [31:0] res_imag;
    logic               equal_flag;
    logic               div_zero;
    logic               saturated;
  } res_t;

  typedef struct packed {
    logic        neg_r;
    logic        neg_i;
    logic [63:0] mag_r;
    logic [63:0] mag_i;
    logic [63:0] den;
  } div_cmd_t;

  typedef struct packed {
    logic [31:0] re;
    logic [31:0] im;
    logic        sat;
  } div_res_t;

  // {saturated, value} of a 33-bit signed sum clamped to 32 bits
  function automatic logic [32:0] sat33(input logic [32:0] v);
    if (v[32] != v[31]) begin
      return {1'b1, v[32] ? 32'h8000_0000 : 32'h7fff_ffff};
    end
    return {1'b0, v[31:0]};
  endfunction

  // {saturated, value} of a 65-bit signed value clamped to 32 bits
  function automatic logic [32:0] sat65(input logic [64:0] v);
    if (v[64:31] != {34{v[64]}}) begin
      return {1'b1, v[64] ? 32'h8000_0000 : 32'h7fff_ffff};
    end
    return {1'b0, v[31:0]};
  endfunction

endpackage

`default_nettype wire

>>> design/cau_front.sv
`default_nettype none

module cau_front (
  input  wire              clk,
  input  wire              rst,
  input  wire              req_valid,
  output logic             req_ready,
  input  cau_pkg::req_t    req,
  output logic             head_valid,
  input  wire              head_pop,
  output cau_pkg::req_t    head
);

  cau_pkg::req_t fifo [2];
  logic          wptr;
  logic          rptr;
  logic [1:0]    count;
  logic          push;
  cau_pkg::req_t item;

  // norm reuses the a*b products with b replaced by a
  always_comb begin
    item = req;
    if (req.kind == cau_pkg::KIND_NORM) begin
      item.b_real = req.a_real;
      item.b_imag = req.a_imag;
    end
  end

  assign req_ready  = (count != 2'd2);
  assign push       = req_valid && req_ready;
  assign head_valid = (count != 2'd0);
  assign head       = fifo[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      fifo[wptr] <= item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) begin
        wptr <= ~wptr;
      end
      if (head_pop) begin
        rptr <= ~rptr;
      end
      count <= count + {1'b0, push} - {1'b0, head_pop};
    end
  end

endmodule

`default_nettype wire

>>> design/cau_div.sv
`default_nettype none

module cau_div #(
  parameter int FRAC_BITS = 16
) (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  start,
  input  cau_pkg::div_cmd_t    cmd,
  output logic                 busy,
  output logic                 done,
  input  wire                  take,
  output cau_pkg::div_res_t    result
);

  localparam int NW = 64 + FRAC_BITS;
  localparam int CW = $clog2(cau_pkg::DIV_QBITS + 1);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_RUN  = 3'b010,
    ST_DONE = 3'b100
  } state_t;

  state_t      state;
  logic [CW-1:0] cnt;
  logic [63:0] den;
  logic [NW-1:0] num [2];
  logic [63:0] rem [2];
  logic [cau_pkg::DIV_QBITS-1:0] q [2];
  logic        ovf [2];
  logic        neg [2];
  logic [NW-1:0] hi [2];
  logic [64:0] t [2];
  logic [64:0] d [2];
  logic [31:0] val [2];
  logic        lsat [2];

  always_comb begin
    for (int i = 0; i < 2; i++) begin
      hi[i] = num[i] >> cau_pkg::DIV_QBITS;
      t[i]  = {rem[i], num[i][cau_pkg::DIV_QBITS-1]};
      d[i]  = t[i] - {1'b0, den};
      if (neg[i]) begin
        lsat[i] = ovf[i] || (q[i] > cau_pkg::DIV_QBITS'(34'h0_8000_0000));
        val[i]  = lsat[i] ? 32'h8000_0000 : (32'd0 - q[i][31:0]);
      end else begin
        lsat[i] = ovf[i] || (q[i] > cau_pkg::DIV_QBITS'(34'h0_7fff_ffff));
        val[i]  = lsat[i] ? 32'h7fff_ffff : q[i][31:0];
      end
    end
  end

  assign busy   = (state != ST_IDLE);
  assign done   = (state == ST_DONE);
  assign result = '{re: val[0], im: val[1], sat: lsat[0] || lsat[1]};

  always_ff @(posedge clk) begin
    if (start) begin
      den    <= cmd.den;
      num[0] <= NW'(cmd.mag_r) << FRAC_BITS;
      num[1] <= NW'(cmd.mag_i) << FRAC_BITS;
      neg[0] <= cmd.neg_r;
      neg[1] <= cmd.neg_i;
    end else if (state == ST_RUN) begin
      for (int i = 0; i < 2; i++) begin
        if (cnt == '0) begin
          ovf[i] <= (hi[i] >= NW'(den));
          rem[i] <= hi[i][63:0];
          q[i]   <= '0;
        end else begin
          num[i] <= num[i] << 1;
          if (!d[i][64]) begin
            rem[i] <= d[i][63:0];
            q[i]   <= {q[i][cau_pkg::DIV_QBITS-2:0], 1'b1};
          end else begin
            rem[i] <= t[i][63:0];
            q[i]   <= {q[i][cau_pkg::DIV_QBITS-2:0], 1'b0};
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (start) begin
            state <= ST_RUN;
            cnt   <= '0;
          end
        end
        ST_RUN: begin
          if (cnt == CW'(cau_pkg::DIV_QBITS)) begin
            state <= ST_DONE;
          end
          cnt <= cnt + 1'b1;
        end
        ST_DONE: begin
          if (take) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

>>> design/cau_back.sv
`default_nettype none

module cau_back #(
  parameter int FRAC_BITS = 16
) (
  input  wire              clk,
  input  wire              rst,
  input  wire              head_valid,
  output logic             head_pop,
  input  cau_pkg::req_t    head,
  output logic             res_valid,
  input  wire              res_ready,
  output cau_pkg::res_t    res
);

  logic               s1_v;
  logic [2:0]         s1_kind;
  logic signed [63:0] p_rr, p_ii, p_ri, p_ir, p_br, p_bi;
  cau_pkg::res_t      s1_simple;
  cau_pkg::res_t      simple;
  cau_pkg::res_t      s2_res;
  logic [32:0]        c_re, c_im;
  logic signed [64:0] s_mre, s_mim, s_dre, s_dim;
  logic [64:0]        m_re, m_im;
  logic [63:0]        den;
  cau_pkg::div_cmd_t  cmd;
  cau_pkg::div_res_t  dres;
  logic               div_busy, div_done, div_start, div_go;
  logic               out_free, s1_adv, o_load_s1, o_load_div;
  logic [32:0]        k_re, k_im;

  // operations that need no product
  always_comb begin
    simple = '0;
    case (head.kind)
      cau_pkg::KIND_ADD: begin
        c_re = cau_pkg::sat33(33'(head.a_real) + 33'(head.b_real));
        c_im = cau_pkg::sat33(33'(head.a_imag) + 33'(head.b_imag));
      end
      cau_pkg::KIND_SUB: begin
        c_re = cau_pkg::sat33(33'(head.a_real) - 33'(head.b_real));
        c_im = cau_pkg::sat33(33'(head.a_imag) - 33'(head.b_imag));
      end
      default: begin
        c_re = {1'b0, head.a_real};
        c_im = cau_pkg::sat33(33'sd0 - 33'(head.a_imag));
      end
    endcase
    case (head.kind) inside
      cau_pkg::KIND_ADD, cau_pkg::KIND_SUB, cau_pkg::KIND_CONJ: begin
        simple.res_real  = c_re[31:0];
        simple.res_imag  = c_im[31:0];
        simple.saturated = c_re[32] || c_im[32];
      end
      cau_pkg::KIND_EQUAL: begin
        simple.equal_flag = (head.a_real == head.b_real) && (head.a_imag == head.b_imag);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (head_pop) begin
      s1_kind   <= head.kind;
      s1_simple <= simple;
      p_rr      <= head.a_real * head.b_real;
      p_ii      <= head.a_imag * head.b_imag;
      p_ri      <= head.a_real * head.b_imag;
      p_ir      <= head.a_imag * head.b_real;
      p_br      <= head.b_real * head.b_real;
      p_bi      <= head.b_imag * head.b_imag;
    end
  end

  // sums of products, divider command and the result of mul, norm and divide by zero
  always_comb begin
    s_mre = 65'(p_rr) - 65'(p_ii);
    s_mim = 65'(p_ri) + 65'(p_ir);
    s_dre = 65'(p_rr) + 65'(p_ii);
    s_dim = 65'(p_ir) - 65'(p_ri);
    m_re  = s_dre[64] ? (65'd0 - s_dre) : s_dre;
    m_im  = s_dim[64] ? (65'd0 - s_dim) : s_dim;
    den   = p_br + p_bi;
    cmd   = '{neg_r: s_dre[64], neg_i: s_dim[64], mag_r: m_re[63:0], mag_i: m_im[63:0],
              den: den};
    k_re  = '0;
    k_im  = '0;
    s2_res = s1_simple;
    case (s1_kind)
      cau_pkg::KIND_MUL: begin
        k_re = cau_pkg::sat65(s_mre >>> FRAC_BITS);
        k_im = cau_pkg::sat65(s_mim >>> FRAC_BITS);
        s2_res = '{res_real: k_re[31:0], res_imag: k_im[31:0], equal_flag: 1'b0,
                   div_zero: 1'b0, saturated: k_re[32] || k_im[32]};
      end
      cau_pkg::KIND_NORM: begin
        k_re = cau_pkg::sat65(s_dre >>> FRAC_BITS);
        s2_res = '{res_real: k_re[31:0], res_imag: 32'd0, equal_flag: 1'b0,
                   div_zero: 1'b0, saturated: k_re[32]};
      end
      cau_pkg::KIND_DIV: begin
        s2_res = '{res_real: 32'd0, res_imag: 32'd0, equal_flag: 1'b0,
                   div_zero: 1'b1, saturated: 1'b0};
      end
      default: ;
    endcase
  end

  assign out_free   = !res_valid || res_ready;
  assign div_go     = (s1_kind == cau_pkg::KIND_DIV) && (den != 64'd0);
  assign s1_adv     = s1_v && !div_busy && (div_go || out_free);
  assign div_start  = s1_adv && div_go;
  assign o_load_s1  = s1_adv && !div_go;
  assign o_load_div = div_done && out_free;
  assign head_pop   = head_valid && (!s1_v || s1_adv);

  cau_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk    (clk),
    .rst    (rst),
    .start  (div_start),
    .cmd    (cmd),
    .busy   (div_busy),
    .done   (div_done),
    .take   (o_load_div),
    .result (dres)
  );

  always_ff @(posedge clk) begin
    if (o_load_div) begin
      res <= '{res_real: dres.re, res_imag: dres.im, equal_flag: 1'b0,
               div_zero: 1'b0, saturated: dres.sat};
    end else if (o_load_s1) begin
      res <= s2_res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v      <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      if (head_pop) begin
        s1_v <= 1'b1;
      end else if (s1_adv) begin
        s1_v <= 1'b0;
      end
      if (o_load_div || o_load_s1) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

`ifndef SYNTHESIS
  a_no_double_load: assert property (@(posedge clk) disable iff (rst)
    !(o_load_div && o_load_s1))
    else $error("divider and pipeline load output together");
  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    div_start |-> !div_busy)
    else $error("divide started while divider busy");
  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    div_start |=> div_busy)
    else $error("divider did not take the request");
  a_dz_zero: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res.div_zero) |-> (res.res_real == 32'd0 && res.res_imag == 32'd0))
    else $error("division by zero with non-zero result");
`endif

endmodule

`default_nettype wire

>>> design/complex_arith_unit.sv
// Every kind passes the queue, the product stage and the output register; a
// divide by non-zero also runs the 35-step restoring divider. Throughput: one
// request per cycle for all but divide while the output is taken; a divide holds
// the back end while the two-entry queue takes up to two more requests.
// Reset: synchronous, active high; clears queue, pipeline and divider control.
`default_nettype none

module complex_arith_unit #(
  parameter int FRAC_BITS = 16
) (
  input  wire              clk,
  input  wire              rst,
  input  wire              req_valid,
  output logic             req_ready,
  input  cau_pkg::req_t    req,
  output logic             res_valid,
  input  wire              res_ready,
  output cau_pkg::res_t    res
);

  logic          head_valid;
  logic          head_pop;
  cau_pkg::req_t head;

  cau_front u_front (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_ready  (req_ready),
    .req        (req),
    .head_valid (head_valid),
    .head_pop   (head_pop),
    .head       (head)
  );

  cau_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_pop   (head_pop),
    .head       (head),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res        (res)
  );

endmodule

`default_nettype wire
